@@ hdl/rda_pkg.sv @@
`timescale 1ns / 1ps
package rda_pkg;

	// Command format: Q.12, full deflection at 4096
	localparam int CMD_W      = 14;
	localparam int FULL_SCALE = 4096;

	// Arithmetic constants
	localparam int DT_FIX       = 409;
	localparam int GAIN_DIV     = 100;
	// five hundredths of (dr / dt) truncates the same as dr / (dt * 20)
	localparam int YAW_DIFF_DIV = DT_FIX * 20;
	localparam int INTEG_DIV    = 200000;

	// State and register widths
	localparam int INTEG_W    = 22;
	localparam int LIMIT_W    = 21;
	localparam int BIAS_W     = 14;
	localparam int SLEW_W     = 14;
	localparam int STEPS_W    = 8;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// Largest integral quotient the limit register allows
	localparam int INTEG_QMAX = ((1 << LIMIT_W) - 1) / INTEG_DIV;

	localparam logic [STEPS_W-1:0] TICK_MAX = '1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ELEVATOR_BIAS,
		REG_ELEVATOR_SLEW_LIMIT,
		REG_INTEGRAL_LIMIT,
		REG_WARMUP_STEPS,
		REG_PITCH_RATE_GAIN,
		REG_PITCH_DIFF_GAIN,
		REG_ROLL_TO_RUDDER_GAIN,
		REG_YAW_TO_AILERON_GAIN
	} rda_reg_t;

	// Register file contents; signed members are raw two's complement bits
	typedef struct packed {
		logic [BIAS_W-1:0]  elevator_bias;
		logic [SLEW_W-1:0]  elevator_slew_limit;
		logic [LIMIT_W-1:0] integral_limit;
		logic [STEPS_W-1:0] warmup_steps;
		logic [GAIN_W-1:0]  pitch_rate_gain;
		logic [GAIN_W-1:0]  pitch_diff_gain;
		logic [GAIN_W-1:0]  roll_to_rudder_gain;
		logic [GAIN_W-1:0]  yaw_to_aileron_gain;
	} rda_cfg_t;

	localparam rda_cfg_t CFG_RESET = '{
		elevator_bias:       BIAS_W'(614),
		elevator_slew_limit: SLEW_W'(136),
		integral_limit:      LIMIT_W'(1288568),
		warmup_steps:        STEPS_W'(9),
		pitch_rate_gain:     GAIN_W'(14),
		pitch_diff_gain:     GAIN_W'(10),
		roll_to_rudder_gain: GAIN_W'(40),
		yaw_to_aileron_gain: GAIN_W'(-60)
	};

endpackage

@@ hdl/rda_if.sv @@
`timescale 1ns / 1ps

// Body rate word, Q.12
interface rda_rate_if #(
	parameter int RATE_WIDTH = 18
) ();
	logic                         valid;
	logic                         ready;
	logic signed [RATE_WIDTH-1:0] roll_rate;
	logic signed [RATE_WIDTH-1:0] pitch_rate;
	logic signed [RATE_WIDTH-1:0] yaw_rate;

	modport source (output valid, output roll_rate, output pitch_rate, output yaw_rate,
		input ready);
	modport sink (input valid, input roll_rate, input pitch_rate, input yaw_rate,
		output ready);
endinterface

// Surface command word, Q.12
interface rda_cmd_if
	import rda_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] elevator_cmd;
	logic signed [CMD_W-1:0] rudder_cmd;
	logic signed [CMD_W-1:0] aileron_cmd;

	modport source (output valid, output elevator_cmd, output rudder_cmd,
		output aileron_cmd, input ready);
	modport sink (input valid, input elevator_cmd, input rudder_cmd,
		input aileron_cmd, output ready);
endinterface

@@ hdl/rate_damping_autopilot_fixed_core.sv @@
`timescale 1ns / 1ps
// channel | dir | handshake   | word
// rates   | in  | valid/ready | roll_rate, pitch_rate, yaw_rate (RATE_WIDTH, Q.12)
// cmds    | out | valid/ready | elevator_cmd, rudder_cmd, aileron_cmd (14 bit, Q.12)
// cfg     | in  | cfg_wr_en   | cfg_index, cfg_data (write only, no read-back)
//
// One word per cycle sustained while cmds is ready; a word's commands pass,
// after it is taken, through five register stages: input, products, constant
// divides and integrator, sums and clamps, slew limit and output.
// The integrator and the elevator slew feedback each close inside one stage.
// Reset clears the stage valids and the rate, integral, elevator and tick
// history, and loads the register defaults; there is no clearing pass.
// A stage moves when the next one is empty or moving, so rates keeps taking
// words during an output stall until all five stages are full.
module rate_damping_autopilot_fixed_core
	import rda_pkg::*;
#(
	parameter int RATE_WIDTH = 18
) (
	input logic                  clk,
	input logic                  arst_n,
	rda_rate_if.sink             rates,
	rda_cmd_if.source            cmds,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RW   = RATE_WIDTH;
	localparam int DW   = RW + 1;            // rate difference
	localparam int PW   = RW + GAIN_W;       // gain times rate
	localparam int PDW  = DW + GAIN_W;       // gain times difference
	localparam int QIW  = RW + 9;            // rate times dt
	localparam int QW   = PW - 6;            // gain product over 100
	localparam int QDW  = PDW - 6;
	localparam int YDW  = DW - 12;           // yaw difference over 8180
	localparam int IW   = ((INTEG_W > QIW) ? INTEG_W : QIW) + 1;
	localparam int IDW  = $clog2(INTEG_QMAX + 1) + 1;
	localparam int SW   = ((QDW > BIAS_W) ? QDW : BIAS_W) + 2;
	localparam int AW   = QW + 1;
	localparam int LW   = ((CMD_W > SLEW_W) ? CMD_W : SLEW_W) + 2;

	rda_cfg_t cfg;

	rda_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake and stage control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic take;

	always_comb begin
		adv5 = !valid_s5 || cmds.ready;
		adv4 = !valid_s4 || adv5;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
	end

	assign rates.ready = adv1;
	assign take        = rates.valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= rates.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: rate differences against the last word, warm-up gate
	logic signed [RW-1:0] prev_pitch_q, prev_yaw_q;
	logic [STEPS_W-1:0]   tick_q;
	logic                 warm;
	logic signed [DW-1:0] dq_in, dr_in;
	logic signed [RW-1:0] p_s1, q_s1, r_s1;
	logic signed [DW-1:0] dq_s1, dr_s1;

	assign warm  = tick_q < cfg.warmup_steps;
	assign dq_in = warm ? '0 : DW'(rates.pitch_rate) - DW'(prev_pitch_q);
	assign dr_in = DW'(rates.yaw_rate) - DW'(prev_yaw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pitch_q <= '0;
			prev_yaw_q   <= '0;
			tick_q       <= '0;
		end else if (take) begin
			prev_pitch_q <= rates.pitch_rate;
			prev_yaw_q   <= rates.yaw_rate;
			if (tick_q != TICK_MAX) tick_q <= tick_q + STEPS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_s1  <= rates.roll_rate;
			q_s1  <= rates.pitch_rate;
			r_s1  <= rates.yaw_rate;
			dq_s1 <= dq_in;
			dr_s1 <= dr_in;
		end
	end

	// Stage 2: gain products and integrator step
	logic signed [PW-1:0]  gq_s2, gp_s2, gr_s2;
	logic signed [PDW-1:0] gdq_s2;
	logic signed [QIW-1:0] qi_s2;
	logic signed [DW-1:0]  dr_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			gq_s2  <= PW'($signed(cfg.pitch_rate_gain)) * PW'(q_s1);
			gdq_s2 <= PDW'($signed(cfg.pitch_diff_gain)) * PDW'(dq_s1);
			gp_s2  <= PW'($signed(cfg.roll_to_rudder_gain)) * PW'(p_s1);
			gr_s2  <= PW'($signed(cfg.yaw_to_aileron_gain)) * PW'(r_s1);
			qi_s2  <= QIW'(q_s1) * QIW'(DT_FIX);
			dr_s2  <= dr_s1;
		end
	end

	// Stage 3: divide by constants, accumulate and clamp the integral
	logic signed [QW-1:0]      qa_w, qr_w, ya_w;
	logic signed [QDW-1:0]     qb_w;
	logic signed [YDW-1:0]     yd_w;
	logic signed [IW-1:0]      integ_sum, integ_lim, integ_clamped;
	logic signed [INTEG_W-1:0] integ_q, integ_next;
	logic signed [QW-1:0]      qa_s3, qr_s3, ya_s3;
	logic signed [QDW-1:0]     qb_s3;
	logic signed [YDW-1:0]     yd_s3;
	logic signed [INTEG_W-1:0] integ_s3;

	rda_cdiv #(.IN_W(PW), .OUT_W(QW), .DIVISOR(GAIN_DIV)) u_div_pitch (
		.num (gq_s2),
		.quo (qa_w)
	);

	rda_cdiv #(.IN_W(PDW), .OUT_W(QDW), .DIVISOR(GAIN_DIV)) u_div_pitch_diff (
		.num (gdq_s2),
		.quo (qb_w)
	);

	rda_cdiv #(.IN_W(PW), .OUT_W(QW), .DIVISOR(GAIN_DIV)) u_div_roll (
		.num (gp_s2),
		.quo (qr_w)
	);

	rda_cdiv #(.IN_W(PW), .OUT_W(QW), .DIVISOR(GAIN_DIV)) u_div_yaw (
		.num (gr_s2),
		.quo (ya_w)
	);

	rda_cdiv #(.IN_W(DW), .OUT_W(YDW), .DIVISOR(YAW_DIFF_DIV)) u_div_yaw_diff (
		.num (dr_s2),
		.quo (yd_w)
	);

	assign integ_sum = IW'(integ_q) + IW'(qi_s2);
	assign integ_lim = $signed(IW'({1'b0, cfg.integral_limit}));

	always_comb begin
		if (integ_sum > integ_lim) begin
			integ_clamped = integ_lim;
		end else if (integ_sum < -integ_lim) begin
			integ_clamped = -integ_lim;
		end else begin
			integ_clamped = integ_sum;
		end
	end

	assign integ_next = INTEG_W'(integ_clamped);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (adv3 && valid_s2) begin
			integ_q <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			qa_s3    <= qa_w;
			qb_s3    <= qb_w;
			qr_s3    <= qr_w;
			ya_s3    <= ya_w;
			yd_s3    <= yd_w;
			integ_s3 <= integ_next;
		end
	end

	// Stage 4: integral over 200000, sums, clamp to full scale
	localparam logic signed [SW-1:0] FS_S = SW'(FULL_SCALE);
	localparam logic signed [QW-1:0] FS_R = QW'(FULL_SCALE);
	localparam logic signed [AW-1:0] FS_A = AW'(FULL_SCALE);

	logic                      integ_neg;
	logic [INTEG_W-1:0]        integ_mag;
	logic [IDW-2:0]            idiv_mag;
	logic signed [IDW-1:0]     idiv;
	logic signed [SW-1:0]      elev_sum;
	logic signed [AW-1:0]      ail_sum;
	logic signed [CMD_W-1:0]   val_w, rud_w, ail_w;
	logic signed [CMD_W-1:0]   val_s4, rud_s4, ail_s4;

	assign integ_neg = integ_s3[INTEG_W-1];
	assign integ_mag = integ_neg ? INTEG_W'(-integ_s3) : INTEG_W'(integ_s3);

	// Quotient is the largest k with k times the divisor not above the magnitude
	always_comb begin
		idiv_mag = '0;
		for (int k = 1; k <= INTEG_QMAX; k++) begin
			if (integ_mag >= INTEG_W'(k * INTEG_DIV)) idiv_mag = (IDW-1)'(k);
		end
	end

	assign idiv = integ_neg ? -$signed(IDW'(idiv_mag)) : $signed(IDW'(idiv_mag));

	assign elev_sum = SW'(qa_s3) + SW'(qb_s3) + SW'(idiv)
		+ SW'($signed(cfg.elevator_bias));
	assign ail_sum  = AW'(ya_s3) + AW'(yd_s3);

	always_comb begin
		if (elev_sum > FS_S) begin
			val_w = CMD_W'(FS_S);
		end else if (elev_sum < -FS_S) begin
			val_w = CMD_W'(-FS_S);
		end else begin
			val_w = CMD_W'(elev_sum);
		end

		if (qr_s3 > FS_R) begin
			rud_w = CMD_W'(FS_R);
		end else if (qr_s3 < -FS_R) begin
			rud_w = CMD_W'(-FS_R);
		end else begin
			rud_w = CMD_W'(qr_s3);
		end

		if (ail_sum > FS_A) begin
			ail_w = CMD_W'(FS_A);
		end else if (ail_sum < -FS_A) begin
			ail_w = CMD_W'(-FS_A);
		end else begin
			ail_w = CMD_W'(ail_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			val_s4 <= val_w;
			rud_s4 <= rud_w;
			ail_s4 <= ail_w;
		end
	end

	// Stage 5: slew limit against the last elevator command, output register
	logic signed [CMD_W-1:0] prev_elev_q;
	logic signed [LW-1:0]    slew, elev_hi, elev_lo, val_l, elev_l;
	logic signed [CMD_W-1:0] elev_w;
	logic signed [CMD_W-1:0] elev_s5, rud_s5, ail_s5;

	assign slew    = $signed(LW'({1'b0, cfg.elevator_slew_limit}));
	assign elev_hi = LW'(prev_elev_q) + slew;
	assign elev_lo = LW'(prev_elev_q) - slew;
	assign val_l   = LW'(val_s4);

	always_comb begin
		if (val_l > elev_hi) begin
			elev_l = elev_hi;
		end else if (val_l < elev_lo) begin
			elev_l = elev_lo;
		end else begin
			elev_l = val_l;
		end
	end

	assign elev_w = CMD_W'(elev_l);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_elev_q <= '0;
		end else if (adv5 && valid_s4) begin
			prev_elev_q <= elev_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			elev_s5 <= elev_w;
			rud_s5  <= rud_s4;
			ail_s5  <= ail_s4;
		end
	end

	assign cmds.valid        = valid_s5;
	assign cmds.elevator_cmd = elev_s5;
	assign cmds.rudder_cmd   = rud_s5;
	assign cmds.aileron_cmd  = ail_s5;

endmodule

@@ hdl/rda_cfg_regs.sv @@
`timescale 1ns / 1ps
module rda_cfg_regs
	import rda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output rda_cfg_t              cfg
);

	rda_cfg_t cfg_q;

	// Write the addressed register, keep the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ELEVATOR_BIAS:       cfg_q.elevator_bias       <= cfg_data[BIAS_W-1:0];
				REG_ELEVATOR_SLEW_LIMIT: cfg_q.elevator_slew_limit <= cfg_data[SLEW_W-1:0];
				REG_INTEGRAL_LIMIT:      cfg_q.integral_limit      <= cfg_data[LIMIT_W-1:0];
				REG_WARMUP_STEPS:        cfg_q.warmup_steps        <= cfg_data[STEPS_W-1:0];
				REG_PITCH_RATE_GAIN:     cfg_q.pitch_rate_gain     <= cfg_data[GAIN_W-1:0];
				REG_PITCH_DIFF_GAIN:     cfg_q.pitch_diff_gain     <= cfg_data[GAIN_W-1:0];
				REG_ROLL_TO_RUDDER_GAIN: cfg_q.roll_to_rudder_gain <= cfg_data[GAIN_W-1:0];
				REG_YAW_TO_AILERON_GAIN: cfg_q.yaw_to_aileron_gain <= cfg_data[GAIN_W-1:0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/rda_cdiv.sv @@
`timescale 1ns / 1ps
// Signed divide by a constant, truncating toward zero.
// The magnitude is multiplied by a rounded-up reciprocal; with the shift one
// divisor-width beyond the input width the floor is exact for every input.
module rda_cdiv #(
	parameter int IN_W    = 26,
	parameter int OUT_W   = 20,
	parameter int DIVISOR = 100
) (
	input  logic signed [IN_W-1:0]  num,
	output logic signed [OUT_W-1:0] quo
);

	localparam int SHIFT  = IN_W + $clog2(DIVISOR);
	localparam int MAGIC_W = IN_W + 2;
	localparam int PROD_W = IN_W + MAGIC_W;
	localparam longint unsigned MAGIC =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic                       neg;
	logic [IN_W-1:0]            mag;
	logic [PROD_W-1:0]          prod;
	logic [PROD_W-SHIFT-1:0]    quo_mag;
	logic signed [OUT_W-1:0]    quo_pos;

	// Split off the sign
	assign neg = num[IN_W-1];
	assign mag = neg ? IN_W'(-num) : IN_W'(num);

	// Reciprocal multiply, keep the integer part
	assign prod    = PROD_W'(mag) * PROD_W'(MAGIC);
	assign quo_mag = prod[PROD_W-1:SHIFT];
	assign quo_pos = $signed(OUT_W'(quo_mag));

	// Restore the sign
	assign quo = neg ? -quo_pos : quo_pos;

endmodule

@@ hdl/rda_checker.sv @@
`timescale 1ns / 1ps
module rda_checker
	import rda_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CMD_W-1:0] elevator_cmd,
	input logic [CMD_W-1:0] rudder_cmd,
	input logic [CMD_W-1:0] aileron_cmd
);

	localparam int PIPE_DEPTH = 5;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
	localparam logic signed [CMD_W-1:0] CMD_HI = CMD_W'(FULL_SCALE);
	localparam logic signed [CMD_W-1:0] CMD_LO = CMD_W'(-FULL_SCALE);

	logic             in_take, out_take;
	logic [CNT_W-1:0] pending_q;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Track words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(in_take) - CNT_W'(out_take);
		end
	end

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			$signed(elevator_cmd) <= CMD_HI && $signed(elevator_cmd) >= CMD_LO &&
			$signed(rudder_cmd) <= CMD_HI && $signed(rudder_cmd) >= CMD_LO &&
			$signed(aileron_cmd) <= CMD_HI && $signed(aileron_cmd) >= CMD_LO)
		else $error("command outside full scale");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(elevator_cmd) && $stable(rudder_cmd) &&
			$stable(aileron_cmd))
		else $error("command word changed during stall");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("command word without a rate word");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words in flight than stages");

	a_empty_open: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> in_ready)
		else $error("empty pipeline refuses a rate word");

endmodule

bind rate_damping_autopilot_fixed_core rda_checker u_rda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rates.valid),
	.in_ready     (rates.ready),
	.out_valid    (cmds.valid),
	.out_ready    (cmds.ready),
	.elevator_cmd (cmds.elevator_cmd),
	.rudder_cmd   (cmds.rudder_cmd),
	.aileron_cmd  (cmds.aileron_cmd)
);
